// ===== hw/rtl/swrl_pkg.sv =====
// Shared types and constants of the sliding-window send rate limiter.
// No dependencies; imported by the limiter unit, swrl_div and the bench, not by swrl_ram.
`timescale 1ns / 1ps

package swrl_pkg;

   localparam int FRAME_W    = 32;
   localparam int BYTES_W    = 16;
   localparam int TIME_W     = 32;
   localparam int RATE_W     = 20;
   localparam int TOTAL_W    = 22;
   localparam int COUNT_W    = 32;
   localparam int DELAY_W    = 26;
   localparam int MOD_CNT_W  = 6;
   localparam int DIV_CNT_W  = 5;

   localparam logic [DELAY_W-1:0] MS_PER_SECOND = DELAY_W'(1000);

   localparam logic CMD_CHECK  = 1'b0;
   localparam logic CMD_RECORD = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [FRAME_W-1:0] frame_number;
      logic [BYTES_W-1:0] sent_bytes;
      logic               link_spawned;
      logic [TIME_W-1:0]  now_ms;
   } req_type;

   typedef struct packed {
      logic               dropped;
      logic [TOTAL_W-1:0] window_total;
      logic [COUNT_W-1:0] suppressed_frames;
      logic [TIME_W-1:0]  send_time;
      logic [DELAY_W-1:0] send_delay;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_DIV,
      ST_FIN
   } state_type;

endpackage

// ===== hw/rtl/sliding_window_send_rate_limiter_unit.sv =====
// Sliding-window send rate limiter: ring of frame sizes in a RAM, serial sum,
// reciprocal-multiply slot and total reduction, radix-2 divider for the pacing delay.
// One item at a time: a check or a zero-rate record runs the ring scan, then its result;
// a limited record runs the ring scan, product and 26-step divide before its result.
// The next item can be taken once the result is registered; a waiting result holds the block in ST_FIN.
// Reset is synchronous; the ring valid bits all clear together, no sweep.
`timescale 1ns / 1ps

module sliding_window_send_rate_limiter_unit
   import swrl_pkg::*;
#(
   parameter int WINDOW       = 16,
   parameter int RATE_DIVISOR = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [RATE_W-1:0] csr_wdata
);

   localparam int IDX_W      = $clog2(WINDOW);
   localparam int CNT_W      = $clog2(WINDOW + 1);
   localparam int SLOT_STEPS = 2;
   localparam int SUM_SH     = $clog2(RATE_DIVISOR);
   localparam logic [FRAME_W:0] SLOT_RECIP = (FRAME_W + 1)'(
      ((64'd1 << (FRAME_W + IDX_W)) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
   localparam logic [TOTAL_W:0] SUM_RECIP = (TOTAL_W + 1)'(
      ((64'd1 << (TOTAL_W + SUM_SH)) + 64'(RATE_DIVISOR) - 64'd1) / 64'(RATE_DIVISOR));

   state_type            state_ff, state_in;
   logic                 cmd_ff, cmd_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic [BYTES_W-1:0]   bytes_ff, bytes_in;
   logic                 spawned_ff, spawned_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [TOTAL_W-1:0]   acc_ff, acc_in;
   logic [MOD_CNT_W-1:0] mod_cnt_ff, mod_cnt_in;
   logic [IDX_W-1:0]     slot_q_ff, slot_q_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [DELAY_W-1:0]   prod_ff, prod_in;
   logic [RATE_W-1:0]    rate_ff, rate_in;
   logic [WINDOW-1:0]    valid_ff, valid_in;
   logic [COUNT_W-1:0]   suppress_ff, suppress_in;
   logic [TIME_W-1:0]    send_time_ff, send_time_in;
   logic [DELAY_W-1:0]   send_delay_ff, send_delay_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 ram_we;
   logic [BYTES_W-1:0]   ram_rdata;
   logic [BYTES_W-1:0]   ring_word;
   logic                 div_start;
   logic [DELAY_W-1:0]   div_dividend;
   logic [RATE_W-1:0]    div_divisor;
   logic                 div_done;
   logic [DELAY_W-1:0]   div_quot;
   logic                 scan_issue;
   logic                 mod_busy;
   logic                 scan_done;
   logic [2*FRAME_W:0]   slot_prod;
   logic [2*TOTAL_W:0]   sum_prod;
   logic [TOTAL_W-1:0]   total_q;
   logic                 over;

   swrl_ram #(
      .WIDTH (BYTES_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (slot_ff),
      .wdata (bytes_ff),
      .raddr (scan_ff[IDX_W-1:0]),
      .rdata (ram_rdata)
   );

   swrl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rate_in   = csr_we ? csr_wdata : rate_ff;
   assign ring_word = valid_ff[rd_idx_ff] ? ram_rdata : '0;
   assign slot_prod = frame_ff * SLOT_RECIP;
   assign sum_prod  = acc_ff * SUM_RECIP;
   assign total_q   = total_ff;
   assign over      = (rate_ff != '0) && (TOTAL_W'(rate_ff) < total_q);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      frame_in      = frame_ff;
      bytes_in      = bytes_ff;
      spawned_in    = spawned_ff;
      now_in        = now_ff;
      scan_in       = scan_ff;
      rd_pend_in    = 1'b0;
      rd_idx_in     = rd_idx_ff;
      acc_in        = acc_ff;
      mod_cnt_in    = mod_cnt_ff;
      slot_q_in     = slot_q_ff;
      slot_in       = slot_ff;
      total_in      = total_ff;
      prod_in       = prod_ff;
      valid_in      = valid_ff;
      suppress_in   = suppress_ff;
      send_time_in  = send_time_ff;
      send_delay_in = send_delay_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      div_start     = 1'b0;
      div_dividend  = prod_ff;
      div_divisor   = rate_ff;
      req_ready     = 1'b0;

      scan_issue = scan_ff != CNT_W'(WINDOW);
      mod_busy   = mod_cnt_ff != MOD_CNT_W'(SLOT_STEPS);
      scan_done  = !scan_issue && !rd_pend_ff && !mod_busy;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in     = req_data.cmd;
               frame_in   = req_data.frame_number;
               bytes_in   = req_data.sent_bytes;
               spawned_in = req_data.link_spawned;
               now_in     = req_data.now_ms;
               scan_in    = '0;
               acc_in     = '0;
               mod_cnt_in = '0;
               slot_in    = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_pend_in = scan_issue;
            rd_idx_in  = scan_ff[IDX_W-1:0];
            if (scan_issue) begin
               scan_in = scan_ff + 1'b1;
            end
            if (rd_pend_ff) begin
               acc_in = acc_ff + TOTAL_W'(ring_word);
            end
            if (mod_busy) begin
               if (mod_cnt_ff == '0) begin
                  slot_q_in = IDX_W'(slot_prod >> (FRAME_W + IDX_W));
               end else begin
                  slot_in = frame_ff[IDX_W-1:0] - IDX_W'(slot_q_ff * WINDOW);
               end
               mod_cnt_in = mod_cnt_ff + 1'b1;
            end
            if (scan_done) begin
               if (cmd_ff == CMD_CHECK) begin
                  total_in = TOTAL_W'(sum_prod >> (TOTAL_W + SUM_SH));
                  state_in = ST_FIN;
               end else if (rate_ff == '0) begin
                  state_in = ST_FIN;
               end else begin
                  prod_in  = DELAY_W'(bytes_ff) * MS_PER_SECOND;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.dropped      = 1'b0;
               rsp_data_in.window_total = '0;
               if (cmd_ff == CMD_CHECK) begin
                  rsp_data_in.dropped      = over;
                  rsp_data_in.window_total = total_q;
                  if (over) begin
                     suppress_in       = suppress_ff + 1'b1;
                     valid_in[slot_ff] = 1'b0;
                  end
               end else begin
                  send_time_in  = now_ff;
                  send_delay_in = (rate_ff == '0) ? '0 : div_quot;
                  if (rate_ff != '0 && spawned_ff) begin
                     ram_we            = 1'b1;
                     valid_in[slot_ff] = 1'b1;
                  end
               end
               rsp_data_in.suppressed_frames = suppress_in;
               rsp_data_in.send_time         = send_time_in;
               rsp_data_in.send_delay        = send_delay_in;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_pend_ff    <= 1'b0;
         rate_ff       <= '0;
         valid_ff      <= '0;
         suppress_ff   <= '0;
         send_time_ff  <= '0;
         send_delay_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_pend_ff    <= rd_pend_in;
         rate_ff       <= rate_in;
         valid_ff      <= valid_in;
         suppress_ff   <= suppress_in;
         send_time_ff  <= send_time_in;
         send_delay_ff <= send_delay_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      frame_ff    <= frame_in;
      bytes_ff    <= bytes_in;
      spawned_ff  <= spawned_in;
      now_ff      <= now_in;
      scan_ff     <= scan_in;
      rd_idx_ff   <= rd_idx_in;
      acc_ff      <= acc_in;
      mod_cnt_ff  <= mod_cnt_in;
      slot_q_ff   <= slot_q_in;
      slot_ff     <= slot_in;
      total_ff    <= total_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_ram_write_on_record: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_FIN) && (cmd_ff == CMD_RECORD) && (rate_ff != '0))
      else $error("ring written outside a limited record");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide phase");

   a_drop_has_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.dropped) |-> (rsp_data_ff.window_total != '0))
      else $error("drop reported with an empty window");

   a_suppress_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (suppress_ff != $past(suppress_ff))) |->
      ((suppress_ff == $past(suppress_ff) + 1'b1) && ($past(state_ff) == ST_FIN)))
      else $error("suppression counter moved other than by one drop");
`endif

endmodule

// ===== hw/rtl/swrl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module swrl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/swrl_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on swrl_pkg for the operand widths.
`timescale 1ns / 1ps

module swrl_div
   import swrl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DELAY_W-1:0] dividend,
   input  logic [RATE_W-1:0]  divisor,
   output logic               done,
   output logic [DELAY_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DELAY_W-1:0]   q_ff, q_in;
   logic [RATE_W-1:0]    r_ff, r_in;
   logic [RATE_W-1:0]    d_ff, d_in;
   logic [RATE_W:0]      r_sh;
   logic                 ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      r_sh    = {r_ff, q_ff[DELAY_W-1]};
      ge      = r_sh >= {1'b0, d_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
      end else if (busy_ff) begin
         r_in = ge ? RATE_W'(r_sh - {1'b0, d_ff}) : r_sh[RATE_W-1:0];
         q_in = {q_ff[DELAY_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DELAY_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ===== bench/swrl_outcome_checker.sv =====
// Outcome checker for the sliding-window send rate limiter: watches the req, rsp
// and csr ports, keeps its own copy of ring, counters and rate, and compares results.
// Depends on swrl_pkg for the item types and field widths.
`timescale 1ns / 1ps

module swrl_outcome_checker
   import swrl_pkg::*;
#(
   parameter int WINDOW       = 16,
   parameter int RATE_DIVISOR = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  req_type           req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [RATE_W-1:0] csr_wdata,
   output int                errors,
   output int                pending
);

   localparam logic [31:0] MS_PER_S  = 32'd1000;
   localparam int          MAX_LINES = 40;

   logic [BYTES_W-1:0] size_ring [WINDOW];
   logic [COUNT_W-1:0] suppress_count;
   logic [TIME_W-1:0]  last_send_time;
   logic [DELAY_W-1:0] last_send_delay;
   logic [RATE_W-1:0]  rate_limit;
   rsp_type            frame_outcomes [$];
   int                 mismatch_count = 0;
   int                 outstanding = 0;

   assign errors  = mismatch_count;
   assign pending = outstanding;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < MAX_LINES) begin
         $display("%0t rate limiter mismatch on %s: got %0h, expected %0h",
                  $time, what, got, want);
      end
      mismatch_count++;
   endtask

   function automatic rsp_type limit_frame(input req_type item);
      rsp_type     res;
      logic [31:0] slot;
      logic [31:0] ring_sum;
      logic [31:0] pace;
      int          k;
      res  = '0;
      slot = item.frame_number % 32'(WINDOW);
      if (item.cmd == CMD_CHECK) begin
         ring_sum = '0;
         for (k = 0; k < WINDOW; k++) begin
            ring_sum += 32'(size_ring[k]);
         end
         ring_sum = ring_sum / 32'(RATE_DIVISOR);
         if (rate_limit != '0 && ring_sum > 32'(rate_limit)) begin
            res.dropped     = 1'b1;
            suppress_count  = suppress_count + 1'b1;
            size_ring[slot] = '0;
         end
         res.window_total = ring_sum[TOTAL_W-1:0];
      end else begin
         last_send_time = item.now_ms;
         if (rate_limit == '0) begin
            last_send_delay = '0;
         end else begin
            if (item.link_spawned) begin
               size_ring[slot] = item.sent_bytes;
            end
            pace            = (32'(item.sent_bytes) * MS_PER_S) / 32'(rate_limit);
            last_send_delay = pace[DELAY_W-1:0];
         end
      end
      res.suppressed_frames = suppress_count;
      res.send_time         = last_send_time;
      res.send_delay        = last_send_delay;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      int      k;
      if (reset) begin
         for (k = 0; k < WINDOW; k++) begin
            size_ring[k] = '0;
         end
         suppress_count  = '0;
         last_send_time  = '0;
         last_send_delay = '0;
         rate_limit      = '0;
         frame_outcomes.delete();
      end else begin
         if (csr_we) begin
            rate_limit = csr_wdata;
         end
         if (rsp_valid && rsp_ready) begin
            if (frame_outcomes.size() == 0) begin
               report_mismatch("unexpected item", 64'(rsp_data), '0);
            end else begin
               want = frame_outcomes.pop_front();
               if (rsp_data.dropped !== want.dropped)
                  report_mismatch("dropped", 64'(rsp_data.dropped), 64'(want.dropped));
               if (rsp_data.window_total !== want.window_total)
                  report_mismatch("window_total", 64'(rsp_data.window_total),
                                  64'(want.window_total));
               if (rsp_data.suppressed_frames !== want.suppressed_frames)
                  report_mismatch("suppressed_frames", 64'(rsp_data.suppressed_frames),
                                  64'(want.suppressed_frames));
               if (rsp_data.send_time !== want.send_time)
                  report_mismatch("send_time", 64'(rsp_data.send_time), 64'(want.send_time));
               if (rsp_data.send_delay !== want.send_delay)
                  report_mismatch("send_delay", 64'(rsp_data.send_delay),
                                  64'(want.send_delay));
            end
         end
         if (req_valid && req_ready) begin
            frame_outcomes.push_back(limit_frame(req_data));
         end
      end
      outstanding <= frame_outcomes.size();
   end

endmodule

// ===== bench/tb_sliding_window_send_rate_limiter_unit.sv =====
// Testbench top for sliding_window_send_rate_limiter_unit: drives frames, rate
// writes and backpressure; results are judged by swrl_outcome_checker.
// Depends on swrl_pkg, the block and bench/swrl_outcome_checker.sv.
`timescale 1ns / 1ps

module tb_sliding_window_send_rate_limiter_unit;
   import swrl_pkg::*;

   localparam int WINDOW        = 16;
   localparam int RATE_DIVISOR  = 1;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 275;
   localparam int SETTLE_CYCLES = 70;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam logic [RATE_W-1:0] RATE_MAX = '1;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_we = 1'b0;
   logic [RATE_W-1:0] csr_wdata = '0;

   int errors;
   int pending;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int cycle_count = 0;

   sliding_window_send_rate_limiter_unit #(
      .WINDOW       (WINDOW),
      .RATE_DIVISOR (RATE_DIVISOR)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   swrl_outcome_checker #(
      .WINDOW       (WINDOW),
      .RATE_DIVISOR (RATE_DIVISOR)
   ) outcome_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .errors    (errors),
      .pending   (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_sliding_window_send_rate_limiter_unit: errors");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic req_type make_item(input logic cmd, input logic [FRAME_W-1:0] frame,
                                         input logic [BYTES_W-1:0] bytes,
                                         input logic spawned,
                                         input logic [TIME_W-1:0] stamp);
      req_type item;
      item.cmd          = cmd;
      item.frame_number = frame;
      item.sent_bytes   = bytes;
      item.link_spawned = spawned;
      item.now_ms       = stamp;
      return item;
   endfunction

   function automatic logic [BYTES_W-1:0] pick_bytes();
      case ($urandom_range(2))
         0: return BYTES_W'($urandom_range(2000));
         1: return BYTES_W'($urandom_range(65535, 60000));
         default: return BYTES_W'($urandom);
      endcase
   endfunction

   function automatic logic [RATE_W-1:0] phase_rate(input int phase);
      case (phase)
         0: return RATE_W'(1);
         1: return RATE_W'(300000);
         2: return '0;
         3: return RATE_W'(1000000);
         4: return RATE_MAX;
         default: return RATE_W'($urandom_range(700000, 100000));
      endcase
   endfunction

   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_rate(input logic [RATE_W-1:0] rate);
      csr_we    <= 1'b1;
      csr_wdata <= rate;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int                 phase;
      int                 sent;
      bit                 paused;
      logic [FRAME_W-1:0] frame;
      logic [TIME_W-1:0]  stamp;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // rate zero after reset: unlimited check and record, ring stays empty
      send_item(make_item(CMD_CHECK, '0, '0, 1'b0, '0));
      send_item(make_item(CMD_RECORD, '0, '1, 1'b1, '1));
      send_item(make_item(CMD_CHECK, '1, '1, 1'b1, '1));
      wait_quiet();

      // smallest rate: full-size records, unspawned record, then drops
      set_rate(RATE_W'(1));
      send_item(make_item(CMD_RECORD, '0, '1, 1'b1, '0));
      send_item(make_item(CMD_RECORD, 32'd1, 16'd1, 1'b0, 32'd12345));
      send_item(make_item(CMD_RECORD, '1, '1, 1'b1, 32'h8000_0000));
      send_item(make_item(CMD_CHECK, 32'd16, '0, 1'b0, '0));
      send_item(make_item(CMD_CHECK, 32'd2, '0, 1'b1, '1));
      wait_quiet();

      // back to unlimited with a non-empty ring
      set_rate('0);
      send_item(make_item(CMD_CHECK, 32'd15, '0, 1'b0, '0));
      send_item(make_item(CMD_RECORD, 32'd15, '0, 1'b1, 32'd5));
      wait_quiet();

      // all-ones rate, beyond the nominal range
      set_rate(RATE_MAX);
      send_item(make_item(CMD_RECORD, 32'd3, '1, 1'b1, 32'd77));
      send_item(make_item(CMD_CHECK, 32'd3, '1, 1'b1, 32'd78));
      wait_quiet();

      set_rate(RATE_W'(1000000));
      send_item(make_item(CMD_RECORD, 32'hAAAA_AAAA, 16'h5555, 1'b1, 32'h5555_5555));
      send_item(make_item(CMD_RECORD, 32'h5555_5555, 16'hAAAA, 1'b1, 32'hAAAA_AAAA));
      send_item(make_item(CMD_CHECK, '0, 16'h5555, 1'b0, 32'hAAAA_AAAA));
      send_item(make_item(CMD_RECORD, 32'd7, '1, 1'b0, '1));
      wait_quiet();

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase < 2) begin
            send_idle_pct = 29;
            recv_idle_pct <= 62;
         end else if (phase < 4) begin
            send_idle_pct = 62;
            recv_idle_pct <= 29;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end
         set_rate(phase_rate(phase));
         if (phase == 1 || phase == 4) begin
            hold_requests <= hold_requests + 1;
         end
         frame  = $urandom;
         stamp  = $urandom;
         sent   = 0;
         paused = 1'b0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(99) < 80) begin
               // one server frame: check, then record what went out
               frame = frame + 1'b1;
               stamp = stamp + TIME_W'($urandom_range(40, 1));
               send_item(make_item(CMD_CHECK, frame, BYTES_W'($urandom),
                                   1'($urandom_range(1)), stamp));
               send_item(make_item(CMD_RECORD, frame, pick_bytes(),
                                   ($urandom_range(9) != 0), stamp + 1'b1));
               sent += 2;
            end else begin
               send_item(make_item(1'($urandom_range(1)), FRAME_W'($urandom),
                                   BYTES_W'($urandom), 1'($urandom_range(1)),
                                   TIME_W'($urandom)));
               sent++;
            end
            if (phase == 3 && !paused && sent >= PHASE_ITEMS / 2) begin
               wait_quiet();
               paused = 1'b1;
            end
         end
         wait_quiet();
      end

      if (errors == 0) begin
         $display("tb_sliding_window_send_rate_limiter_unit: clean");
      end else begin
         $display("tb_sliding_window_send_rate_limiter_unit: errors");
      end
      $finish;
   end

endmodule
